FILE: rtl/tice_pkg.sv
// Shared types, codes and the scan-code table for the text insert cursor engine.
// No dependencies; every other file in rtl imports this package.
package tice_pkg;

   // Width of a cell address on the store command bus (enough for 8192 cells).
   localparam int STORE_AW = 13;

   // Item function codes.
   localparam logic [1:0] FUNC_SCAN = 2'd0;
   localparam logic [1:0] FUNC_TICK = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;
   localparam logic [1:0] FUNC_LOAD = 2'd3;

   // PS/2 set-2 scan codes with a meaning of their own.
   localparam logic [7:0] CODE_BREAK     = 8'hF0;
   localparam logic [7:0] CODE_EXT       = 8'hE0;
   localparam logic [7:0] CODE_LEFT      = 8'h6B;
   localparam logic [7:0] CODE_RIGHT     = 8'h74;
   localparam logic [7:0] CODE_BACKSPACE = 8'h66;
   localparam logic [7:0] CODE_ESCAPE    = 8'h76;
   localparam logic [7:0] CODE_ENTER     = 8'h5A;
   localparam logic [7:0] CODE_SPACE     = 8'h29;

   // Input item.
   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  scan_byte;
      logic [12:0] cell_address;
      logic [7:0]  cell_char;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [12:0] cursor;
      logic        blink_on;
      logic        exit_insert;
      logic [7:0]  read_char;
   } rsp_type;

   // Command from the sequencer to the character store.
   typedef struct packed {
      logic                rd_en;
      logic [STORE_AW-1:0] rd_addr;
      logic                wr_en;
      logic [STORE_AW-1:0] wr_addr;
      logic [7:0]          wr_data;
   } mem_cmd_type;

   // Letters a to z and space; every other code maps to zero.
   function automatic logic [7:0] scan_to_char(input logic [7:0] code);
      logic [7:0] ch;
      case (code)
         8'h1C: ch = "a";  8'h32: ch = "b";  8'h21: ch = "c";  8'h23: ch = "d";
         8'h24: ch = "e";  8'h2B: ch = "f";  8'h34: ch = "g";  8'h33: ch = "h";
         8'h43: ch = "i";  8'h3B: ch = "j";  8'h42: ch = "k";  8'h4B: ch = "l";
         8'h3A: ch = "m";  8'h31: ch = "n";  8'h44: ch = "o";  8'h4D: ch = "p";
         8'h15: ch = "q";  8'h2D: ch = "r";  8'h1B: ch = "s";  8'h2C: ch = "t";
         8'h3C: ch = "u";  8'h2A: ch = "v";  8'h1D: ch = "w";  8'h22: ch = "x";
         8'h35: ch = "y";  8'h1A: ch = "z";
         CODE_SPACE: ch = " ";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/tice_store.sv
// Character store: one write port and one read port with registered read data.
// Depends on tice_pkg for the store command type.
module tice_store #(
   parameter int DEPTH = 4800
) (
   input  logic                 clock,
   input  tice_pkg::mem_cmd_type mem_cmd,
   output logic [7:0]           rd_data_ff
);
   import tice_pkg::*;

   localparam int MW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem[mem_cmd.wr_addr[MW-1:0]] <= mem_cmd.wr_data;
      end
   end

   // Read port, with registered read data.
   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_data_ff <= mem[mem_cmd.rd_addr[MW-1:0]];
      end
   end

endmodule

FILE: rtl/tice_ctrl.sv
// Sequencer of the text insert cursor engine: key decoding, cursor walks and
// the clearing pass. Depends on tice_pkg; drives the character store command.
module tice_ctrl #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 60
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tice_pkg::req_type     req_data,
   output tice_pkg::mem_cmd_type mem_cmd,
   input  logic [7:0]            rd_data,
   input  logic                  slot_free,
   output logic                  done_valid,
   output tice_pkg::rsp_type     done_data
);
   import tice_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS + 1);
   localparam int CW    = $clog2(COLUMNS);
   localparam logic [AW-1:0] CELLS_P = AW'(CELLS);
   localparam logic [AW-1:0] LAST_P  = AW'(CELLS - 1);
   localparam logic [CW-1:0] COL_MAX = CW'(COLUMNS - 1);

   typedef enum logic [9:0] {
      ST_CLEAR      = 10'b00_0000_0001,
      ST_IDLE       = 10'b00_0000_0010,
      ST_READ       = 10'b00_0000_0100,
      ST_LEFT       = 10'b00_0000_1000,
      ST_RIGHT_FIRST = 10'b00_0001_0000,
      ST_RIGHT      = 10'b00_0010_0000,
      ST_BACK_FIRST = 10'b00_0100_0000,
      ST_BACK       = 10'b00_1000_0000,
      ST_ENTER      = 10'b01_0000_0000,
      ST_DONE       = 10'b10_0000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [AW-1:0] p_ff, p_in;
   logic [CW-1:0] col_ff, col_in;
   logic          walked_ff, walked_in;
   logic          blink_ff, blink_in;
   logic          skip_ff, skip_in;
   logic          ext_ff, ext_in;
   logic          exit_ff, exit_in;
   logic [7:0]    rd_ff, rd_in;

   logic [7:0]    ch;
   logic          cell_nz;
   logic          addr_ok;
   logic [AW-1:0] p_inc, p_dec, cur_inc, cur_dec;
   logic [CW-1:0] col_inc, col_dec, cur_col_inc, cur_col_dec;

   // Neighbouring positions of the walk pointer and of the cursor, with columns.
   always_comb begin
      p_inc       = p_ff + 1'b1;
      p_dec       = p_ff - 1'b1;
      col_inc     = (col_ff == COL_MAX) ? '0 : col_ff + 1'b1;
      col_dec     = (col_ff == '0) ? COL_MAX : col_ff - 1'b1;
      cur_inc     = cursor_ff + 1'b1;
      cur_dec     = cursor_ff - 1'b1;
      cur_col_inc = (cur_col_ff == COL_MAX) ? '0 : cur_col_ff + 1'b1;
      cur_col_dec = (cur_col_ff == '0) ? COL_MAX : cur_col_ff - 1'b1;
      ch          = scan_to_char(req_data.scan_byte);
      // The cell at the walk pointer, read in the previous cycle; past the end it is empty.
      cell_nz     = (p_ff < CELLS_P) && (rd_data != 8'h00);
      addr_ok     = 32'(req_data.cell_address) < 32'(CELLS);
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in   = state_ff;
      cursor_in  = cursor_ff;
      cur_col_in = cur_col_ff;
      p_in       = p_ff;
      col_in     = col_ff;
      walked_in  = walked_ff;
      blink_in   = blink_ff;
      skip_in    = skip_ff;
      ext_in     = ext_ff;
      exit_in    = exit_ff;
      rd_in      = rd_ff;
      mem_cmd    = '0;
      req_stall  = 1'b1;
      done_valid = 1'b0;

      unique case (state_ff)
         // Zero the whole store after reset, one cell a cycle.
         ST_CLEAR: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = STORE_AW'(p_ff);
            mem_cmd.wr_data = 8'h00;
            if (p_ff == LAST_P) begin
               p_in     = '0;
               state_in = ST_IDLE;
            end else begin
               p_in = p_inc;
            end
         end

         // Take an item and start its work.
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               exit_in  = 1'b0;
               rd_in    = 8'h00;
               state_in = ST_DONE;
               unique case (req_data.func)
                  FUNC_SCAN: begin
                     if (skip_ff) begin
                        skip_in = 1'b0;
                     end else if (req_data.scan_byte == CODE_BREAK) begin
                        skip_in = 1'b1;
                        ext_in  = 1'b0;
                     end else if (req_data.scan_byte == CODE_EXT) begin
                        ext_in = 1'b1;
                     end else if (ext_ff) begin
                        ext_in   = 1'b0;
                        blink_in = 1'b0;
                        if (req_data.scan_byte == CODE_LEFT && cursor_ff != '0) begin
                           p_in            = cur_dec;
                           col_in          = cur_col_dec;
                           walked_in       = 1'b0;
                           mem_cmd.rd_en   = 1'b1;
                           mem_cmd.rd_addr = STORE_AW'(cur_dec);
                           state_in        = ST_LEFT;
                        end else if (req_data.scan_byte == CODE_RIGHT &&
                                     cursor_ff < LAST_P) begin
                           p_in            = cursor_ff;
                           col_in          = cur_col_ff;
                           mem_cmd.rd_en   = 1'b1;
                           mem_cmd.rd_addr = STORE_AW'(cursor_ff);
                           state_in        = ST_RIGHT_FIRST;
                        end
                     end else if (req_data.scan_byte == CODE_ESCAPE) begin
                        exit_in = 1'b1;
                     end else begin
                        blink_in = 1'b0;
                        if (req_data.scan_byte == CODE_ENTER) begin
                           if (cursor_ff < CELLS_P) begin
                              p_in     = cur_inc;
                              col_in   = cur_col_inc;
                              state_in = ST_ENTER;
                           end
                        end else if (req_data.scan_byte == CODE_BACKSPACE) begin
                           if (cursor_ff != '0) begin
                              p_in            = cur_dec;
                              col_in          = cur_col_dec;
                              mem_cmd.rd_addr = STORE_AW'(cur_dec);
                           end else begin
                              p_in            = cursor_ff;
                              col_in          = cur_col_ff;
                              mem_cmd.rd_addr = STORE_AW'(cursor_ff);
                           end
                           mem_cmd.rd_en = 1'b1;
                           state_in      = ST_BACK_FIRST;
                        end else if (ch != 8'h00 && cursor_ff < CELLS_P) begin
                           mem_cmd.wr_en   = 1'b1;
                           mem_cmd.wr_addr = STORE_AW'(cursor_ff);
                           mem_cmd.wr_data = ch;
                           cursor_in       = cur_inc;
                           cur_col_in      = cur_col_inc;
                        end
                     end
                  end
                  FUNC_TICK: begin
                     blink_in = ~blink_ff;
                  end
                  FUNC_READ: begin
                     if (addr_ok) begin
                        mem_cmd.rd_en   = 1'b1;
                        mem_cmd.rd_addr = STORE_AW'(req_data.cell_address);
                        state_in        = ST_READ;
                     end
                  end
                  FUNC_LOAD: begin
                     if (addr_ok) begin
                        mem_cmd.wr_en   = 1'b1;
                        mem_cmd.wr_addr = STORE_AW'(req_data.cell_address);
                        mem_cmd.wr_data = req_data.cell_char;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // Read data of a cell read arrives.
         ST_READ: begin
            rd_in    = rd_data;
            state_in = ST_DONE;
         end

         // Left arrow: walk back over empty cells within the row.
         ST_LEFT: begin
            if (p_ff != '0 && !cell_nz && col_ff != '0) begin
               p_in            = p_dec;
               col_in          = col_dec;
               walked_in       = 1'b1;
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = STORE_AW'(p_dec);
            end else begin
               if (walked_ff && cell_nz) begin
                  cursor_in  = p_inc;
                  cur_col_in = col_inc;
               end else begin
                  cursor_in  = p_ff;
                  cur_col_in = col_ff;
               end
               state_in = ST_DONE;
            end
         end

         // Right arrow, first cell: a filled cell is a plain step.
         ST_RIGHT_FIRST: begin
            if (cell_nz) begin
               cursor_in  = p_inc;
               cur_col_in = col_inc;
               state_in   = ST_DONE;
            end else begin
               p_in            = p_inc;
               col_in          = col_inc;
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = STORE_AW'(p_inc);
               state_in        = ST_RIGHT;
            end
         end

         // Right arrow: walk forward over empty cells up to the row end.
         ST_RIGHT: begin
            if (!cell_nz && col_ff != '0 && p_ff < LAST_P) begin
               p_in            = p_inc;
               col_in          = col_inc;
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = STORE_AW'(p_inc);
            end else begin
               cursor_in  = p_ff;
               cur_col_in = col_ff;
               state_in   = ST_DONE;
            end
         end

         // Backspace, first cell: a filled cell is cleared in place.
         ST_BACK_FIRST: begin
            if (cell_nz) begin
               mem_cmd.wr_en   = 1'b1;
               mem_cmd.wr_addr = STORE_AW'(p_ff);
               mem_cmd.wr_data = 8'h00;
               cursor_in       = p_ff;
               cur_col_in      = col_ff;
               state_in        = ST_DONE;
            end else if (p_ff != '0) begin
               p_in            = p_dec;
               col_in          = col_dec;
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = STORE_AW'(p_dec);
               state_in        = ST_BACK;
            end else begin
               cursor_in  = p_ff;
               cur_col_in = col_ff;
               state_in   = ST_DONE;
            end
         end

         // Backspace: walk back over empty cells, across rows.
         ST_BACK: begin
            if (!cell_nz && p_ff != '0) begin
               p_in            = p_dec;
               col_in          = col_dec;
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = STORE_AW'(p_dec);
            end else begin
               if (p_ff != '0) begin
                  cursor_in  = p_inc;
                  cur_col_in = col_inc;
               end else begin
                  cursor_in  = p_ff;
                  cur_col_in = col_ff;
               end
               state_in = ST_DONE;
            end
         end

         // Enter: zero the rest of the row, one cell a cycle.
         ST_ENTER: begin
            if (col_ff != '0 && p_ff < CELLS_P) begin
               mem_cmd.wr_en   = 1'b1;
               mem_cmd.wr_addr = STORE_AW'(p_ff);
               mem_cmd.wr_data = 8'h00;
               p_in            = p_inc;
               col_in          = col_inc;
            end else begin
               cursor_in  = p_ff;
               cur_col_in = col_ff;
               state_in   = ST_DONE;
            end
         end

         // Hand the result to the output register once it has room.
         ST_DONE: begin
            done_valid = 1'b1;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result of the current item.
   always_comb begin
      done_data.cursor      = 13'(cursor_ff);
      done_data.blink_on    = blink_ff;
      done_data.exit_insert = exit_ff;
      done_data.read_char   = rd_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cursor_ff  <= '0;
         cur_col_ff <= '0;
         p_ff       <= '0;
         blink_ff   <= 1'b0;
         skip_ff    <= 1'b0;
         ext_ff     <= 1'b0;
         exit_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cursor_ff  <= cursor_in;
         cur_col_ff <= cur_col_in;
         p_ff       <= p_in;
         blink_ff   <= blink_in;
         skip_ff    <= skip_in;
         ext_ff     <= ext_in;
         exit_ff    <= exit_in;
      end
   end

   // Walk working registers.
   always_ff @(posedge clock) begin
      col_ff    <= col_in;
      walked_ff <= walked_in;
      rd_ff     <= rd_in;
   end

   // The cursor never passes the end of the store.
   assert property (@(posedge clock) disable iff (reset) cursor_ff <= CELLS_P)
      else $error("cursor beyond the end of the store");

   // The cursor column stays inside the row.
   assert property (@(posedge clock) disable iff (reset) 32'(cur_col_ff) < COLUMNS)
      else $error("cursor column out of range");

   // A left walk stays strictly before the cursor it started from.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LEFT |-> p_ff < cursor_ff)
      else $error("left walk passed the cursor");

   // Enter never zeroes a cell at the start of a row.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ENTER && mem_cmd.wr_en) |-> col_ff != '0)
      else $error("enter fill crossed into the next row");

   // The store is never read and written at the same cell in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      (mem_cmd.wr_en && mem_cmd.rd_en) |-> mem_cmd.wr_addr != mem_cmd.rd_addr)
      else $error("read and write collide on one cell");

endmodule

FILE: rtl/text_insert_cursor_engine.sv
// Top level of the text insert cursor engine: sequencer, character store and the
// result register. Depends on tice_pkg, tice_store and tice_ctrl.
//
// After reset the block zeroes all COLUMNS*ROWS cells (4800 at 80x60) of its
// character store, with req_stall high throughout. Then it takes one item at a
// time. A scan byte without a walk, a blink tick or a cell load goes from the idle
// state straight to the done state; a cell read passes through the read state.
// Arrow keys and backspace walk the store cell by cell, and enter zeroes each cell
// to the row end; backspace can walk back over every empty cell to the store's start.
// The walks use the store's single read port with registered read data and visit
// one cell each cycle. A finished result waits in the output register, and the next
// item is taken while it waits.
module text_insert_cursor_engine #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 60
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tice_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tice_pkg::rsp_type rsp_data
);
   import tice_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   mem_cmd_type mem_cmd;
   logic [7:0]  rd_data;
   logic        slot_free;
   logic        rsp_load;
   logic        done_valid;
   rsp_type     done_data;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   tice_ctrl #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .mem_cmd   (mem_cmd),
      .rd_data   (rd_data),
      .slot_free (slot_free),
      .done_valid(done_valid),
      .done_data (done_data)
   );

   tice_store #(
      .DEPTH(CELLS)
   ) u_store (
      .clock     (clock),
      .mem_cmd   (mem_cmd),
      .rd_data_ff(rd_data)
   );

   // Output register: loaded when empty or when its result is taken.
   always_comb begin
      slot_free    = !rsp_valid_ff || !rsp_stall;
      rsp_load     = done_valid && slot_free;
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_in       = rsp_load ? done_data : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
